FILE: rtl/olie_pkg.sv
// Shared types and constants of the ordered list insert/erase unit.
package olie_pkg;

	// List size and stored word width
	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;

	// Field widths of the stream items
	localparam int CMD_W   = 3;
	localparam int POS_W   = 4;
	localparam int VALUE_W = 32;
	localparam int RDV_W   = 32;
	localparam int ECNT_W  = 5;
	localparam int STAT_W  = 2;

	// Count holds 0 to CAPACITY; compares run at the wider of count and position
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Packed item widths, padded to whole bytes
	localparam int IN_BITS  = CMD_W + POS_W + VALUE_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = RDV_W + ECNT_W + STAT_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 3'd0,
		CMD_POP    = 3'd1,
		CMD_CLEAR  = 3'd2,
		CMD_INSERT = 3'd3,
		CMD_ERASE  = 3'd4,
		CMD_READ   = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// Operation broadcast to every cell of the row
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_APPEND,
		OP_INSERT,
		OP_ERASE
	} cell_op_t;

	typedef struct packed {
		cell_op_t              op;
		logic [CMP_W-1:0]      pos;
		logic [CMP_W-1:0]      cnt;
		logic [DATA_WIDTH-1:0] value;
	} cell_ctrl_t;

endpackage

FILE: rtl/olie_cell.sv
// One list cell: holds one entry and takes data from its neighbors on a shift.
module olie_cell (
	input  logic                           clk,
	input  olie_pkg::cell_ctrl_t           ctrl,
	input  logic [olie_pkg::CMP_W-1:0]     idx,
	input  logic [olie_pkg::DATA_WIDTH-1:0] prev_data,
	input  logic [olie_pkg::DATA_WIDTH-1:0] next_data,
	input  logic [olie_pkg::CMP_W-1:0]     rd_pos,
	output logic [olie_pkg::DATA_WIDTH-1:0] data,
	output logic [olie_pkg::DATA_WIDTH-1:0] rd_data
);

	logic [olie_pkg::DATA_WIDTH-1:0] data_q;
	logic [olie_pkg::DATA_WIDTH-1:0] data_d;

	// Pick the next entry from the broadcast operation and this cell's place
	always_comb begin
		data_d = data_q;
		unique case (ctrl.op)
			olie_pkg::OP_APPEND: begin
				if (idx == ctrl.cnt) data_d = ctrl.value;
			end
			olie_pkg::OP_INSERT: begin
				if (idx == ctrl.pos) data_d = ctrl.value;
				else if (idx > ctrl.pos) data_d = prev_data;
			end
			olie_pkg::OP_ERASE: begin
				if (idx >= ctrl.pos) data_d = next_data;
			end
			default: data_d = data_q;
		endcase
	end

	// Hold the entry
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

	// Drive the entry onto the read bus only when addressed
	assign rd_data = (idx == rd_pos) ? data_q : '0;

endmodule

FILE: rtl/ordered_list_insert_erase_unit.sv
// Top level of the ordered list unit: command decode, count, cell row, result register.
//
// Fixed-capacity ordered list of signed words (olie_pkg::CAPACITY entries). Each item
// on the s_ side is one command (push, pop, clear, insert, erase, read) and yields
// exactly one result item on the m_ side with the read value, the count after the
// command and a status. Entries sit in a row of cells that all shift at once, so a new
// item is taken every cycle while the result register is empty or being drained.
// Insert is allowed only below the current count; reads at or past the count return
// 0 with status ignored. Entries are not cleared at reset, only the count is.
module ordered_list_insert_erase_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// [2:0] command, [6:3] position, [38:7] value, [39] zero
	input  logic [olie_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [31:0] read_value, [36:32] entry_count, [38:37] status, [39] zero
	output logic [olie_pkg::OUT_W-1:0]  m_tdata
);

	localparam int CAP = olie_pkg::CAPACITY;
	localparam int DW  = olie_pkg::DATA_WIDTH;

	logic                        accept;
	olie_pkg::cmd_t              cmd;
	logic [olie_pkg::CMP_W-1:0]  pos;
	logic [olie_pkg::CMP_W-1:0]  cnt_ext;
	logic [DW-1:0]               value;
	logic                        full;
	logic                        pos_ok;

	logic [olie_pkg::CNT_W-1:0]  count_q;
	logic [olie_pkg::CNT_W-1:0]  count_d;
	olie_pkg::status_t           status_d;
	logic                        do_read;
	olie_pkg::cell_ctrl_t        ctrl;

	logic [DW-1:0]               cell_data [CAP];
	logic [DW-1:0]               cell_rd   [CAP];
	logic [DW-1:0]               rd_or;

	logic                        m_valid_q;
	logic [olie_pkg::RDV_W-1:0]  rdv_q;
	logic [olie_pkg::ECNT_W-1:0] ecnt_q;
	olie_pkg::status_t           status_q;

	// Unpack the command item
	assign accept  = s_tvalid && s_tready;
	assign cmd     = olie_pkg::cmd_t'(s_tdata[2:0]);
	assign pos     = olie_pkg::CMP_W'(s_tdata[6:3]);
	assign value   = DW'(s_tdata[38:7]);
	assign cnt_ext = olie_pkg::CMP_W'(count_q);
	assign full    = (count_q == olie_pkg::CNT_W'(CAP));
	assign pos_ok  = (pos < cnt_ext);

	// Decode the command into the next count, a status and a cell operation
	always_comb begin
		count_d  = count_q;
		status_d = olie_pkg::ST_DONE;
		do_read  = 1'b0;
		ctrl.op  = olie_pkg::OP_HOLD;
		ctrl.pos = pos;
		ctrl.cnt = cnt_ext;
		ctrl.value = value;
		unique case (cmd)
			olie_pkg::CMD_PUSH: begin
				if (full) begin
					status_d = olie_pkg::ST_FULL;
				end else begin
					ctrl.op = olie_pkg::OP_APPEND;
					count_d = count_q + 1'b1;
				end
			end
			olie_pkg::CMD_POP: begin
				if (count_q == '0) status_d = olie_pkg::ST_IGNORED;
				else count_d = count_q - 1'b1;
			end
			olie_pkg::CMD_CLEAR: begin
				count_d = '0;
			end
			olie_pkg::CMD_INSERT: begin
				if (!pos_ok) begin
					status_d = olie_pkg::ST_IGNORED;
				end else if (full) begin
					status_d = olie_pkg::ST_FULL;
				end else begin
					ctrl.op = olie_pkg::OP_INSERT;
					count_d = count_q + 1'b1;
				end
			end
			olie_pkg::CMD_ERASE: begin
				if (!pos_ok) begin
					status_d = olie_pkg::ST_IGNORED;
				end else begin
					ctrl.op = olie_pkg::OP_ERASE;
					count_d = count_q - 1'b1;
				end
			end
			olie_pkg::CMD_READ: begin
				if (!pos_ok) status_d = olie_pkg::ST_IGNORED;
				else do_read = 1'b1;
			end
			default: status_d = olie_pkg::ST_IGNORED;
		endcase
		if (!accept) ctrl.op = olie_pkg::OP_HOLD;
	end

	// Build the row of cells; the ends see zeros from outside
	for (genvar j = 0; j < CAP; j++) begin : g_cell
		logic [DW-1:0] prev_w;
		logic [DW-1:0] next_w;
		if (j == 0) begin : g_first
			assign prev_w = '0;
		end else begin : g_mid_prev
			assign prev_w = cell_data[j-1];
		end
		if (j == CAP - 1) begin : g_last
			assign next_w = '0;
		end else begin : g_mid_next
			assign next_w = cell_data[j+1];
		end
		olie_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.idx       (olie_pkg::CMP_W'(j)),
			.prev_data (prev_w),
			.next_data (next_w),
			.rd_pos    (pos),
			.data      (cell_data[j]),
			.rd_data   (cell_rd[j])
		);
	end

	// Combine the read bus of all cells
	always_comb begin
		rd_or = '0;
		for (int j = 0; j < CAP; j++) rd_or = rd_or | cell_rd[j];
	end

	// Hold the entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	// Result register: load on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rdv_q    <= do_read ? olie_pkg::RDV_W'(signed'(rd_or)) : '0;
			ecnt_q   <= olie_pkg::ECNT_W'(count_d);
			status_q <= status_d;
		end
	end

	assign s_tready = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = olie_pkg::OUT_W'({status_q, ecnt_q, rdv_q});

	// Count never passes the capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= olie_pkg::CNT_W'(CAP))
		else $error("entry count above capacity");

	// A successful push adds exactly one entry
	a_push_inc: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == olie_pkg::CMD_PUSH && !full
		|=> count_q == $past(count_q) + 1'b1)
		else $error("push did not grow the list by one");

	// Clear empties the list
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == olie_pkg::CMD_CLEAR |=> count_q == '0)
		else $error("clear left entries");

	// Full status only when the list was full
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		accept && status_d == olie_pkg::ST_FULL |-> full)
		else $error("full status on a list with room");

endmodule
